FILE: rtl/assert_macros.svh
// assertion macros used by the text screen character writer unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// condition in one cycle implies a result in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tscw_pkg.sv
// types and constants of the text screen character writer
package tscw_pkg;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_LEAD,
        S_CHAR,
        S_FILL,
        S_TAB,
        S_READ,
        S_WIPE
    } t_state;

    localparam logic [2:0] REQ_PUT    = 3'd0;
    localparam logic [2:0] REQ_MOVE   = 3'd1;
    localparam logic [2:0] REQ_SO_ON  = 3'd2;
    localparam logic [2:0] REQ_SO_OFF = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;
    localparam logic [2:0] REQ_READ   = 3'd5;

    localparam logic [6:0] CH_BEL = 7'h07;
    localparam logic [6:0] CH_TAB = 7'h09;
    localparam logic [6:0] CH_LF  = 7'h0A;
    localparam logic [6:0] CH_FF  = 7'h0C;
    localparam logic [6:0] CH_CR  = 7'h0D;

    localparam logic [7:0] BLANK = 8'h20;

    // tab stops every 8 columns
    localparam int TAB_BITS = 3;

    localparam logic [4:0] LINES_RESET = 5'd25;

endpackage

FILE: rtl/tscw_ram.sv
// generic single-clock ram, one write port and one registered read port
module tscw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/text_screen_char_writer_unit.sv
// top level of the text screen character writer: sequencer, cursor and screen ram
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------------
//  cfg      | i_cfg_we                  | i_cfg_data (screen lines)
//  in       | i_in_valid / o_in_stall   | i_req_type i_char_code i_target_line/_column
//  out      | o_out_valid / i_out_stall | o_accepted o_bell o_cursor_line/_column
//           |                           | o_standout_active o_cell_value
//
// cursor, standout and refused commands end at decode, read cell after the ram read, a
// printable after the two lead blanks at column 0; tab and newline walk blank cells, and
// clear and form feed walk every cell: the single ram write port takes one cell a cycle.
// after reset a clearing pass over all COLUMNS * MAX_LINES cells runs with the input stalled.
// one beat is worked on at a time; the next is taken once the result beat leaves the
// output register, in the same cycle at the earliest.
`include "assert_macros.svh"

module text_screen_char_writer_unit #(
    parameter int COLUMNS   = 80,
    parameter int MAX_LINES = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [4:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_req_type,
    input  logic [6:0]        i_char_code,
    input  logic signed [5:0] i_target_line,
    input  logic signed [7:0] i_target_column,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_accepted,
    output logic              o_bell,
    output logic [4:0]        o_cursor_line,
    output logic [6:0]        o_cursor_column,
    output logic              o_standout_active,
    output logic [7:0]        o_cell_value
);
    import tscw_pkg::*;

    localparam int              CELLS     = COLUMNS * MAX_LINES;
    localparam int              AW        = $clog2(CELLS);
    localparam logic [6:0]      COL_LAST  = 7'(COLUMNS - 1);
    localparam logic [6:0]      COL_END   = 7'(COLUMNS);
    localparam logic [4:0]      LINES_MAX = 5'(MAX_LINES);
    localparam logic [AW-1:0]   CELL_LAST = AW'(CELLS - 1);

    t_state        r_state, n_state;
    logic [4:0]    r_lines_cfg;
    logic [4:0]    r_row, n_row;
    logic [6:0]    r_col, n_col;
    logic          r_so, n_so;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [2:0]    r_req;
    logic [6:0]    r_ch;
    logic [5:0]    r_tl;
    logic [7:0]    r_tc;
    logic          r_out_valid;
    logic          r_out_acc;
    logic          r_out_bell;
    logic [7:0]    r_out_cell;

    logic          accept;
    logic [4:0]    lines_use;
    logic [4:0]    lines_m1;
    logic [4:0]    tl_clamp;
    logic [6:0]    tc_clamp;
    logic          refuse;
    logic [7:0]    col_inc;
    logic [4:0]    row_inc;
    logic          wrap;
    logic          tab_stop;
    logic          fill_last;
    logic          wipe_last;
    logic [4:0]    addr_row;
    logic [6:0]    addr_col;
    logic [AW-1:0] cell_addr;
    logic [AW-1:0] ram_addr;
    logic          ram_we;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic          finish;
    logic          fin_acc;
    logic          fin_bell;
    logic [7:0]    fin_cell;

    assign o_in_stall = !(r_state == S_IDLE && (!r_out_valid || !i_out_stall));
    assign accept     = i_in_valid && !o_in_stall;

    // lines register out of range: zero acts as one, too large acts as the maximum
    always_comb begin
        if (r_lines_cfg == 5'd0) begin
            lines_use = 5'd1;
        end else if (r_lines_cfg > LINES_MAX) begin
            lines_use = LINES_MAX;
        end else begin
            lines_use = r_lines_cfg;
        end
    end
    assign lines_m1 = lines_use - 5'd1;

    always_comb begin
        if (r_tl[5]) begin
            tl_clamp = 5'd0;
        end else if (r_tl[4:0] > lines_m1) begin
            tl_clamp = lines_m1;
        end else begin
            tl_clamp = r_tl[4:0];
        end
        if (r_tc[7]) begin
            tc_clamp = 7'd0;
        end else if (r_tc[6:0] > COL_LAST) begin
            tc_clamp = COL_LAST;
        end else begin
            tc_clamp = r_tc[6:0];
        end
    end

    // shared cursor advance
    assign refuse    = r_row >= lines_use;
    assign col_inc   = {1'b0, r_col} + 8'd1;
    assign row_inc   = r_row + 5'd1;
    assign wrap      = col_inc == {1'b0, COL_END};
    assign tab_stop  = wrap || (col_inc[TAB_BITS-1:0] == '0);
    assign fill_last = r_col == COL_LAST;
    assign wipe_last = r_cnt == CELL_LAST;

    // shared cell address unit
    always_comb begin
        if (r_state == S_EXEC && r_req == REQ_READ) begin
            addr_row = tl_clamp;
            addr_col = tc_clamp;
        end else begin
            addr_row = r_row;
            addr_col = r_col;
        end
    end
    assign cell_addr = AW'(addr_row) * AW'(COLUMNS) + AW'(addr_col);
    assign ram_addr  = (r_state == S_INIT || r_state == S_WIPE) ? r_cnt : cell_addr;

    tscw_ram #(
        .WIDTH(8),
        .DEPTH(CELLS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_addr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_addr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (wipe_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_req)
                    REQ_PUT: begin
                        if (r_ch == CH_FF) begin
                            n_state = S_WIPE;
                        end else if (refuse) begin
                            n_state = S_IDLE;
                        end else if (r_col == 7'd0) begin
                            n_state = S_LEAD;
                        end else begin
                            n_state = S_CHAR;
                        end
                    end
                    REQ_CLEAR: n_state = S_WIPE;
                    REQ_READ:  n_state = S_READ;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_LEAD: n_state = S_CHAR;
            S_CHAR: begin
                case (r_ch)
                    CH_LF:   n_state = S_FILL;
                    CH_TAB:  n_state = S_TAB;
                    default: n_state = S_IDLE;
                endcase
            end
            S_FILL: begin
                if (fill_last) n_state = S_IDLE;
            end
            S_TAB: begin
                if (tab_stop) n_state = S_IDLE;
            end
            S_READ: n_state = S_IDLE;
            S_WIPE: begin
                if (wipe_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_row     = r_row;
        n_col     = r_col;
        n_so      = r_so;
        n_cnt     = r_cnt;
        ram_we    = 1'b0;
        ram_wdata = BLANK;
        finish    = 1'b0;
        fin_acc   = 1'b1;
        fin_bell  = 1'b0;
        fin_cell  = 8'd0;
        case (r_state)
            S_INIT: begin
                ram_we = 1'b1;
                n_cnt  = wipe_last ? '0 : r_cnt + AW'(1);
            end
            S_IDLE: begin
                n_cnt = '0;
            end
            S_EXEC: begin
                case (r_req)
                    REQ_PUT: begin
                        if (r_ch == CH_FF) begin
                            n_cnt = '0;
                        end else if (refuse) begin
                            finish  = 1'b1;
                            fin_acc = 1'b0;
                        end else if (r_col == 7'd0) begin
                            // two plain blanks lead a line
                            ram_we = 1'b1;
                            n_col  = 7'd1;
                        end
                    end
                    REQ_MOVE: begin
                        n_row  = tl_clamp;
                        n_col  = tc_clamp;
                        n_so   = 1'b0;
                        finish = 1'b1;
                    end
                    REQ_SO_ON: begin
                        n_so   = 1'b1;
                        finish = 1'b1;
                    end
                    REQ_SO_OFF: begin
                        n_so   = 1'b0;
                        finish = 1'b1;
                    end
                    REQ_CLEAR: begin
                        n_cnt = '0;
                    end
                    REQ_READ: begin
                        // address goes to the ram this cycle
                    end
                    default: begin
                        finish  = 1'b1;
                        fin_acc = 1'b0;
                    end
                endcase
            end
            S_LEAD: begin
                ram_we = 1'b1;
                n_col  = 7'd2;
            end
            S_CHAR: begin
                case (r_ch)
                    CH_LF, CH_TAB: begin
                        // walked in their own states
                    end
                    CH_CR: begin
                        n_col  = 7'd0;
                        finish = 1'b1;
                    end
                    CH_BEL: begin
                        fin_bell = 1'b1;
                        finish   = 1'b1;
                    end
                    default: begin
                        ram_we    = 1'b1;
                        ram_wdata = {r_so, r_ch};
                        finish    = 1'b1;
                        if (wrap) begin
                            n_col = 7'd0;
                            n_row = row_inc;
                        end else begin
                            n_col = col_inc[6:0];
                        end
                    end
                endcase
            end
            S_FILL: begin
                ram_we = 1'b1;
                if (fill_last) begin
                    n_col  = 7'd0;
                    n_row  = row_inc;
                    finish = 1'b1;
                end else begin
                    n_col = col_inc[6:0];
                end
            end
            S_TAB: begin
                ram_we    = 1'b1;
                ram_wdata = {r_so, BLANK[6:0]};
                finish    = tab_stop;
                if (wrap) begin
                    n_col = 7'd0;
                    n_row = row_inc;
                end else begin
                    n_col = col_inc[6:0];
                end
            end
            S_READ: begin
                fin_cell = ram_rdata;
                finish   = 1'b1;
            end
            S_WIPE: begin
                ram_we = 1'b1;
                if (wipe_last) begin
                    n_cnt  = '0;
                    n_row  = 5'd0;
                    n_col  = 7'd0;
                    n_so   = 1'b0;
                    finish = 1'b1;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_lines_cfg <= LINES_RESET;
            r_row       <= 5'd0;
            r_col       <= 7'd0;
            r_so        <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_lines_cfg <= i_cfg_data;
            end
            r_row <= n_row;
            r_col <= n_col;
            r_so  <= n_so;
            r_cnt <= n_cnt;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req_type;
            r_ch  <= i_char_code;
            r_tl  <= i_target_line;
            r_tc  <= i_target_column;
        end
        if (finish) begin
            r_out_acc  <= fin_acc;
            r_out_bell <= fin_bell;
            r_out_cell <= fin_cell;
        end
    end

    // cursor registers hold still while a result beat waits
    assign o_out_valid       = r_out_valid;
    assign o_accepted        = r_out_acc;
    assign o_bell            = r_out_bell;
    assign o_cursor_line     = r_row;
    assign o_cursor_column   = r_col;
    assign o_standout_active = r_so;
    assign o_cell_value      = r_out_cell;

    `ASSERT_ALWAYS(a_col_range, r_col < COL_END, "cursor column beyond screen width")
    `ASSERT_ALWAYS(a_idle_no_write, !(r_state == S_IDLE && ram_we), "ram written while idle")
    `ASSERT_NEXT(a_accept_exec, accept, r_state == S_EXEC, "accepted beat not decoded")
    `ASSERT_NEXT(a_finish_out, finish, o_out_valid && r_state == S_IDLE, "result beat lost")

endmodule

FILE: bench/tb_text_screen_char_writer_unit.sv
// testbench for the text screen character writer: commands checked against a screen mirror
module tb_text_screen_char_writer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tscw_pkg::*;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;
    localparam logic [6:0] SPACE_CODE = BLANK[6:0];
    localparam int PHASE_ITEMS = 272;
    localparam int IDLE_LIMIT = 10000;

    typedef struct packed {
        logic       accepted;
        logic       bell;
        logic [4:0] line;
        logic [6:0] column;
        logic       standout;
        logic [7:0] cell_value;
    } t_status;

    // mirror of screen, cursor and standout; holds the status beats still due
    class screen_mirror;
        logic [7:0] cells [COLS*ROWS];
        int         row;
        int         col;
        bit         standout;
        logic [4:0] lines_reg;
        t_status    due_status [$];
        int         errors;

        function new();
            lines_reg = LINES_RESET;
            errors = 0;
            wipe();
        endfunction

        function int lines_used();
            if (lines_reg < 1) return 1;
            if (lines_reg > ROWS) return ROWS;
            return int'(lines_reg);
        endfunction

        function int pending();
            return due_status.size();
        endfunction

        function void poke(int r, int c, logic [7:0] v);
            if (r < ROWS && c < COLS) cells[r*COLS + c] = v;
        endfunction

        function void wipe();
            foreach (cells[i]) cells[i] = BLANK;
            row = 0;
            col = 0;
            standout = 0;
        endfunction

        function int clamp(int v, int hi);
            if (v < 0) return 0;
            if (v > hi) return hi;
            return v;
        endfunction

        // printable store with the column-0 blanks; does nothing past the last line
        function void put_glyph(logic [6:0] ch);
            if (row >= lines_used()) return;
            if (col == 0) begin
                poke(row, 0, BLANK);
                poke(row, 1, BLANK);
                col = 2;
            end
            poke(row, col, {standout, ch});
            col++;
            if (col >= COLS) begin
                col = 0;
                row++;
            end
        endfunction

        function void note_request(logic [2:0] req, logic [6:0] ch, int tl, int tc);
            t_status res;
            int lines;
            int n;
            res = '0;
            res.accepted = 1'b1;
            lines = lines_used();
            case (req)
                REQ_PUT: begin
                    if (ch == CH_FF) begin
                        wipe();
                    end else if (row >= lines) begin
                        res.accepted = 1'b0;
                    end else begin
                        if (col == 0) begin
                            poke(row, 0, BLANK);
                            poke(row, 1, BLANK);
                            col = 2;
                        end
                        if (ch == CH_LF) begin
                            for (n = col; n < COLS; n++) poke(row, n, BLANK);
                            row++;
                            col = 0;
                        end else if (ch == CH_CR) begin
                            col = 0;
                        end else if (ch == CH_TAB) begin
                            n = 0;
                            do begin
                                put_glyph(SPACE_CODE);
                                n++;
                            end while (col != 0 && col % 8 != 0 && n <= COLS);
                        end else if (ch == CH_BEL) begin
                            res.bell = 1'b1;
                        end else begin
                            put_glyph(ch);
                        end
                    end
                end
                REQ_MOVE: begin
                    row = clamp(tl, lines - 1);
                    col = clamp(tc, COLS - 1);
                    standout = 0;
                end
                REQ_SO_ON: standout = 1;
                REQ_SO_OFF: standout = 0;
                REQ_CLEAR: wipe();
                REQ_READ: begin
                    res.cell_value = cells[clamp(tl, lines - 1)*COLS + clamp(tc, COLS - 1)];
                end
                default: res.accepted = 1'b0;
            endcase
            res.line = row[4:0];
            res.column = col[6:0];
            res.standout = standout;
            due_status.push_back(res);
        endfunction

        function void flag_field(string name, logic [7:0] want, logic [7:0] got);
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        endfunction

        function void check_result(t_status got);
            t_status want;
            if (due_status.size() == 0) begin
                errors++;
                $display("%0t: status beat with none due, expected none got %h", $time, got);
                return;
            end
            want = due_status.pop_front();
            if (got.accepted !== want.accepted)
                flag_field("accepted", want.accepted, got.accepted);
            if (got.bell !== want.bell)
                flag_field("bell", want.bell, got.bell);
            if (got.line !== want.line)
                flag_field("cursor_line", want.line, got.line);
            if (got.column !== want.column)
                flag_field("cursor_column", want.column, got.column);
            if (got.standout !== want.standout)
                flag_field("standout_active", want.standout, got.standout);
            if (got.cell_value !== want.cell_value)
                flag_field("cell_value", want.cell_value, got.cell_value);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [4:0]        i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [2:0]        i_req_type;
    logic [6:0]        i_char_code;
    logic signed [5:0] i_target_line;
    logic signed [7:0] i_target_column;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_accepted;
    logic              o_bell;
    logic [4:0]        o_cursor_line;
    logic [6:0]        o_cursor_column;
    logic              o_standout_active;
    logic [7:0]        o_cell_value;

    screen_mirror mirror = new();
    bit calm = 1'b0;
    int idle_cycles = 0;

    text_screen_char_writer_unit #(
        .COLUMNS   (COLS),
        .MAX_LINES (ROWS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_char_code       (i_char_code),
        .i_target_line     (i_target_line),
        .i_target_column   (i_target_column),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_accepted        (o_accepted),
        .o_bell            (o_bell),
        .o_cursor_line     (o_cursor_line),
        .o_cursor_column   (o_cursor_column),
        .o_standout_active (o_standout_active),
        .o_cell_value      (o_cell_value)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            mirror.check_result({o_accepted, o_bell, o_cursor_line, o_cursor_column,
                                 o_standout_active, o_cell_value});
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side stalls in bursts, none in the closing phase
    initial begin
        forever begin
            if (calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    task automatic send_cmd(logic [2:0] req, logic [6:0] ch, int tl, int tc);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_char_code <= ch;
        i_target_line <= 6'(tl);
        i_target_column <= 8'(tc);
        do @(posedge i_clk); while (o_in_stall);
        mirror.note_request(req, ch, int'(6'(tl) ^ 6'sd0) - (tl[5] ? 64 : 0) + 0,
                            int'(8'(tc)) - (tc[7] ? 256 : 0));
    endtask

    // register write only once every status beat is back and the block sits idle
    task automatic set_lines(logic [4:0] v);
        i_in_valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        i_cfg_data <= v;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mirror.lines_reg = v;
    endtask

    task automatic run_random(int count);
        logic [2:0] req;
        logic [6:0] ch;
        int tl;
        int tc;
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            ch = 7'($urandom_range(0, 127));
            tl = $urandom_range(0, 63) - 32;
            tc = $urandom_range(0, 255) - 128;
            if (pick < 55) begin
                req = REQ_PUT;
                pick = $urandom_range(0, 99);
                if (pick < 66) ch = 7'($urandom_range(32, 126));
                else if (pick < 76) ch = CH_LF;
                else if (pick < 80) ch = CH_CR;
                else if (pick < 87) ch = CH_TAB;
                else if (pick < 91) ch = CH_BEL;
                else if (pick < 92) ch = CH_FF;
            end else if (pick < 67) req = REQ_MOVE;
            else if (pick < 73) req = REQ_SO_ON;
            else if (pick < 77) req = REQ_SO_OFF;
            else if (pick < 78) req = REQ_CLEAR;
            else if (pick < 96) req = REQ_READ;
            else req = $urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7;
            // aim moves and reads at the bottom lines and right edge often
            if ($urandom_range(0, 1)) tl = mirror.lines_used() - 1 - $urandom_range(0, 1);
            case ($urandom_range(0, 2))
                0: tc = $urandom_range(0, COLS - 1);
                1: tc = $urandom_range(COLS - 10, COLS - 1);
                default: ;
            endcase
            send_cmd(req, ch, tl, tc);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_req_type <= REQ_PUT;
        i_char_code <= '0;
        i_target_line <= '0;
        i_target_column <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(REQ_READ, 7'h00, 0, 0);
        send_cmd(REQ_PUT, 7'h41, 0, 0);
        send_cmd(REQ_SO_ON, 7'h00, 0, 0);
        send_cmd(REQ_PUT, 7'h7F, 0, 0);
        send_cmd(REQ_PUT, 7'h00, 0, 0);
        send_cmd(REQ_PUT, CH_TAB, 0, 0);
        send_cmd(REQ_PUT, CH_CR, 0, 0);
        send_cmd(REQ_PUT, CH_TAB, 0, 0);
        send_cmd(REQ_PUT, CH_LF, 0, 0);
        send_cmd(REQ_PUT, CH_BEL, 0, 0);
        send_cmd(REQ_READ, 7'h00, 0, 3);
        send_cmd(REQ_MOVE, 7'h00, -32, -128);
        send_cmd(REQ_MOVE, 7'h00, 31, 127);
        send_cmd(REQ_SO_ON, 7'h00, 0, 0);
        // last cell wraps the cursor past the last line, then all but form feed is refused
        send_cmd(REQ_PUT, 7'h5A, 0, 0);
        send_cmd(REQ_PUT, 7'h51, 0, 0);
        send_cmd(REQ_PUT, CH_LF, 0, 0);
        send_cmd(REQ_PUT, CH_BEL, 0, 0);
        send_cmd(REQ_PUT, CH_FF, 0, 0);
        send_cmd(REQ_SPARE_6, 7'h00, 0, 0);
        send_cmd(REQ_SPARE_7, 7'h00, 0, 0);
        send_cmd(REQ_READ, 7'h00, 31, 127);
        send_cmd(REQ_MOVE, 7'h00, 24, 75);
        send_cmd(REQ_PUT, CH_TAB, 0, 0);
        send_cmd(REQ_CLEAR, 7'h00, 0, 0);

        set_lines(5'd31);
        run_random(PHASE_ITEMS);
        set_lines(5'd0);
        run_random(PHASE_ITEMS);
        set_lines(5'd1);
        run_random(PHASE_ITEMS);
        set_lines(5'd24);
        run_random(PHASE_ITEMS);
        set_lines(5'($urandom_range(2, 23)));
        run_random(PHASE_ITEMS);
        calm = 1'b1;
        set_lines(5'd25);
        run_random(PHASE_ITEMS);

        i_in_valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
